// ----- hdl/alpb_pkg.sv -----
// Shared types, widths and register codes for the antialiased line pixel blender.
package alpb_pkg;

   localparam int CoordWidth = 13;
   localparam int PixelWidth = 12;
   localparam int ColorWidth = 8;
   localparam int LineWidthWidth = 10;
   localparam int RgbWidth = 24;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth = 24;
   localparam int Len8Width = 22;
   localparam int UnitWidth = 16;

   localparam int FrameWidthDefault = 2048;
   localparam int FrameHeightDefault = 2048;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_START_X = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_START_Y = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_END_X = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_END_Y = 4'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_WIDTH = 4'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_RGB = 4'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_OPACITY = 4'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_ALPHA_ONLY = 4'd7;

   // Reset values
   localparam logic [LineWidthWidth-1:0] LINE_WIDTH_RESET = 10'd16;
   localparam logic [RgbWidth-1:0] LINE_RGB_RESET = 24'hFFFFFF;
   localparam logic [ColorWidth-1:0] LINE_OPACITY_RESET = 8'd255;

   // Line geometry derived from the endpoints
   typedef struct packed {
      logic busy;
      logic line_ok;
      logic [Len8Width-1:0] len8;
      logic signed [UnitWidth-1:0] ux;
      logic signed [UnitWidth-1:0] uy;
   } geom_type;

   // Classified pixel passed from front to back
   typedef struct packed {
      logic write_enable;
      logic [ColorWidth-1:0] alpha;
      logic [ColorWidth-1:0] dest_red;
      logic [ColorWidth-1:0] dest_green;
      logic [ColorWidth-1:0] dest_blue;
   } pix_type;

endpackage

// ----- hdl/antialiased_line_pixel_blend_core.sv -----
// Datapath: a req beat passes 5 front stages, the queue and 2 back stages to its rsp beat.
// Throughput: one pixel per cycle while rsp_ready stays high.
// After reset and after any endpoint write, the geometry unit runs a 22-step square root
// and two 15-step divisions with req_ready low.
// Reset is synchronous, active high, and loads the documented register values.
module antialiased_line_pixel_blend_core
   import alpb_pkg::*;
#(
   parameter int FRAME_WIDTH = FrameWidthDefault,
   parameter int FRAME_HEIGHT = FrameHeightDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  logic [PixelWidth-1:0] req_pixel_x,
   input  logic [PixelWidth-1:0] req_pixel_y,
   input  logic [ColorWidth-1:0] req_dest_red,
   input  logic [ColorWidth-1:0] req_dest_green,
   input  logic [ColorWidth-1:0] req_dest_blue,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_write_enable,
   output logic [ColorWidth-1:0] rsp_new_red,
   output logic [ColorWidth-1:0] rsp_new_green,
   output logic [ColorWidth-1:0] rsp_new_blue
);

   logic [CoordWidth-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [LineWidthWidth-1:0] line_width_ff;
   logic [RgbWidth-1:0] line_rgb_ff;
   logic [ColorWidth-1:0] line_opacity_ff;
   logic alpha_only_ff;
   logic restart;
   geom_type geom;
   logic push, q_full, q_not_empty, pop;
   pix_type push_data, pop_data;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff <= '0;
         end_y_ff <= '0;
         line_width_ff <= LINE_WIDTH_RESET;
         line_rgb_ff <= LINE_RGB_RESET;
         line_opacity_ff <= LINE_OPACITY_RESET;
         alpha_only_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_X: start_x_ff <= csr_wdata[CoordWidth-1:0];
            CSR_START_Y: start_y_ff <= csr_wdata[CoordWidth-1:0];
            CSR_END_X: end_x_ff <= csr_wdata[CoordWidth-1:0];
            CSR_END_Y: end_y_ff <= csr_wdata[CoordWidth-1:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[LineWidthWidth-1:0];
            CSR_LINE_RGB: line_rgb_ff <= csr_wdata[RgbWidth-1:0];
            CSR_LINE_OPACITY: line_opacity_ff <= csr_wdata[ColorWidth-1:0];
            CSR_ALPHA_ONLY: alpha_only_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Recompute geometry when an endpoint changes
   assign restart = csr_we && (csr_index == CSR_START_X || csr_index == CSR_START_Y
                    || csr_index == CSR_END_X || csr_index == CSR_END_Y);

   alpb_geom u_geom (
      .clock(clock), .reset(reset), .restart(restart),
      .start_x(start_x_ff), .start_y(start_y_ff), .end_x(end_x_ff), .end_y(end_y_ff),
      .geom(geom)
   );

   alpb_front #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .req_dest_red(req_dest_red), .req_dest_green(req_dest_green),
      .req_dest_blue(req_dest_blue),
      .start_x(start_x_ff), .start_y(start_y_ff),
      .line_width(line_width_ff), .line_opacity(line_opacity_ff),
      .geom(geom), .push(push), .push_data(push_data), .q_full(q_full)
   );

   alpb_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(q_full), .not_empty(q_not_empty), .pop(pop), .pop_data(pop_data)
   );

   alpb_back u_back (
      .clock(clock), .reset(reset), .q_not_empty(q_not_empty), .pop(pop),
      .pop_data(pop_data), .line_rgb(line_rgb_ff), .alpha_only(alpha_only_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_write_enable(rsp_write_enable), .rsp_new_red(rsp_new_red),
      .rsp_new_green(rsp_new_green), .rsp_new_blue(rsp_new_blue)
   );

endmodule

// ----- hdl/alpb_geom.sv -----
// Sequential unit that derives segment length and unit direction from the endpoints.
module alpb_geom
   import alpb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic restart,
   input  logic [CoordWidth-1:0] start_x,
   input  logic [CoordWidth-1:0] start_y,
   input  logic [CoordWidth-1:0] end_x,
   input  logic [CoordWidth-1:0] end_y,
   output geom_type geom
);

   localparam logic [2:0] G_IDLE = 3'd0;
   localparam logic [2:0] G_LOAD = 3'd1;
   localparam logic [2:0] G_SUMSQ = 3'd2;
   localparam logic [2:0] G_SQRT = 3'd3;
   localparam logic [2:0] G_DXI = 3'd4;
   localparam logic [2:0] G_DIVX = 3'd5;
   localparam logic [2:0] G_DYI = 3'd6;
   localparam logic [2:0] G_DIVY = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [13:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [27:0] lsq_ff, lsq_in;
   logic [43:0] rad_ff, rad_in;
   logic [24:0] rem_ff, rem_in;
   logic [Len8Width-1:0] root_ff, root_in;
   logic [21:0] drem_ff, drem_in;
   logic [14:0] num_ff, num_in;
   logic [14:0] q_ff, q_in;
   logic signed [UnitWidth-1:0] ux_ff, ux_in, uy_ff, uy_in;

   logic [24:0] rem_sh, trial;
   logic [22:0] r2;
   logic [34:0] numer;
   logic [12:0] mag_d;
   logic [14:0] qc;
   logic signed [27:0] sq_sum;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      lsq_in = lsq_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      drem_in = drem_ff;
      num_in = num_ff;
      q_in = q_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      rem_sh = {rem_ff[22:0], rad_ff[43:42]};
      trial = {1'b0, root_ff, 2'b01};
      r2 = {drem_ff, num_ff[14]};
      mag_d = (state_ff == G_DYI) ? 13'(dy_ff[13] ? -dy_ff : dy_ff)
                                  : 13'(dx_ff[13] ? -dx_ff : dx_ff);
      numer = {mag_d, 22'b0} + 35'(root_ff >> 1);
      sq_sum = dx_ff * dx_ff + dy_ff * dy_ff;
      qc = 15'd0;
      case (state_ff)
         G_IDLE: begin
         end
         // Latch endpoint differences
         G_LOAD: begin
            dx_in = {end_x[12], end_x} - {start_x[12], start_x};
            dy_in = {end_y[12], end_y} - {start_y[12], start_y};
            state_in = G_SUMSQ;
         end
         G_SUMSQ: begin
            lsq_in = 28'(sq_sum);
            rad_in = {lsq_in, 16'b0};
            rem_in = '0;
            root_in = '0;
            cnt_in = 5'd21;
            state_in = G_SQRT;
         end
         // One root digit per cycle
         G_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[Len8Width-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[Len8Width-2:0], 1'b0};
            end
            rad_in = {rad_ff[41:0], 2'b00};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = G_DXI;
         end
         G_DXI, G_DYI: begin
            drem_in = {2'b00, numer[34:15]};
            num_in = numer[14:0];
            q_in = '0;
            cnt_in = 5'd14;
            state_in = (state_ff == G_DXI) ? G_DIVX : G_DIVY;
         end
         // One quotient bit per cycle
         G_DIVX, G_DIVY: begin
            if (r2 >= {1'b0, root_ff}) begin
               drem_in = 22'(r2 - {1'b0, root_ff});
               q_in = {q_ff[13:0], 1'b1};
            end else begin
               drem_in = r2[21:0];
               q_in = {q_ff[13:0], 1'b0};
            end
            num_in = {num_ff[13:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            qc = (q_in > 15'd16384) ? 15'd16384 : q_in;
            if (cnt_ff == 5'd0) begin
               if (state_ff == G_DIVX) begin
                  ux_in = dx_ff[13] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
                  state_in = G_DYI;
               end else begin
                  uy_in = dy_ff[13] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
                  state_in = G_IDLE;
               end
            end
         end
         default: state_in = G_IDLE;
      endcase
      if (restart) state_in = G_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_LOAD;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      lsq_ff <= lsq_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      num_ff <= num_in;
      q_ff <= q_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
   end

   assign geom.busy = (state_ff != G_IDLE);
   assign geom.line_ok = (lsq_ff != 28'd0);
   assign geom.len8 = root_ff;
   assign geom.ux = ux_ff;
   assign geom.uy = uy_ff;

endmodule

// ----- hdl/alpb_front.sv -----
// Front pipeline: accept pixels, project onto the line, derive coverage and alpha.
module alpb_front
   import alpb_pkg::*;
#(
   parameter int FRAME_WIDTH = FrameWidthDefault,
   parameter int FRAME_HEIGHT = FrameHeightDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [PixelWidth-1:0] req_pixel_x,
   input  logic [PixelWidth-1:0] req_pixel_y,
   input  logic [ColorWidth-1:0] req_dest_red,
   input  logic [ColorWidth-1:0] req_dest_green,
   input  logic [ColorWidth-1:0] req_dest_blue,
   input  logic [CoordWidth-1:0] start_x,
   input  logic [CoordWidth-1:0] start_y,
   input  logic [LineWidthWidth-1:0] line_width,
   input  logic [ColorWidth-1:0] line_opacity,
   input  geom_type geom,
   output logic push,
   output pix_type push_data,
   input  logic q_full
);

   logic en, acc;
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic oka_ff, okb_ff, okc_ff, okd_ff;
   logic [3*ColorWidth-1:0] da_ff, db_ff, dc_ff, dd_ff;
   logic signed [21:0] pxa_ff, pya_ff;
   logic signed [37:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic [24:0] nc_ff;
   logic signed [25:0] tc_ff;
   logic [8:0] cd_ff;
   pix_type pe_ff;

   logic signed [13:0] dfx, dfy;
   logic signed [38:0] nsum, tsum, nmag, tmag, nr, tr;
   logic [24:0] tm;
   logic signed [27:0] n28, t28, hw28, l828, c1, c2;
   logic ok_d;
   logic [16:0] aprod;

   assign en = !ve_ff || !q_full;
   assign req_ready = en && !geom.busy;
   assign acc = req_valid && req_ready;
   assign push = ve_ff && !q_full;
   assign push_data = pe_ff;

   // Stage A: pixel center relative to the start point
   assign dfx = $signed({2'b00, req_pixel_x}) - $signed({start_x[12], start_x});
   assign dfy = $signed({2'b00, req_pixel_y}) - $signed({start_y[12], start_y});

   // Stage C: rounded cross and along distances
   always_comb begin
      nsum = {pb_ff[37], pb_ff} - {pa_ff[37], pa_ff};
      tsum = {pc_ff[37], pc_ff} + {pd_ff[37], pd_ff};
      nmag = nsum[38] ? -nsum : nsum;
      tmag = tsum[38] ? -tsum : tsum;
      nr = nmag + 39'sd8192;
      tr = tmag + 39'sd8192;
      tm = tr[38:14];
   end

   // Stage D: coverage from edge and end falloff
   always_comb begin
      n28 = $signed({3'b000, nc_ff});
      t28 = {{2{tc_ff[25]}}, tc_ff};
      hw28 = $signed({15'b0, line_width, 3'b000});
      l828 = $signed({6'b0, geom.len8});
      ok_d = okc_ff && (n28 <= hw28 + 28'sd256) && (t28 >= -28'sd256)
             && (t28 <= l828 + 28'sd256);
      c1 = (n28 > hw28) ? 28'sd256 - (n28 - hw28) : 28'sd256;
      if (t28 < 0 && (28'sd256 + t28) < c1) c2 = 28'sd256 + t28;
      else if (t28 > l828 && (28'sd256 - (t28 - l828)) < c1) c2 = 28'sd256 - (t28 - l828);
      else c2 = c1;
      if (c2 < 0) c2 = '0;
   end

   assign aprod = 17'(cd_ff * line_opacity) + 17'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (en) begin
         va_ff <= acc;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
      // Advance payload with the valids
      if (en) begin
         pxa_ff <= {dfx, 8'h80};
         pya_ff <= {dfy, 8'h80};
         oka_ff <= geom.line_ok && ({1'b0, req_pixel_x} < 13'(FRAME_WIDTH))
                   && ({1'b0, req_pixel_y} < 13'(FRAME_HEIGHT));
         da_ff <= {req_dest_red, req_dest_green, req_dest_blue};
         pa_ff <= pxa_ff * geom.uy;
         pb_ff <= pya_ff * geom.ux;
         pc_ff <= pxa_ff * geom.ux;
         pd_ff <= pya_ff * geom.uy;
         okb_ff <= oka_ff;
         db_ff <= da_ff;
         nc_ff <= nr[38:14];
         tc_ff <= tsum[38] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
         okc_ff <= okb_ff;
         dc_ff <= db_ff;
         cd_ff <= c2[8:0];
         okd_ff <= ok_d;
         dd_ff <= dc_ff;
         pe_ff.alpha <= aprod[15:8];
         pe_ff.write_enable <= okd_ff && (aprod[15:8] != 8'd0);
         pe_ff.dest_red <= dd_ff[23:16];
         pe_ff.dest_green <= dd_ff[15:8];
         pe_ff.dest_blue <= dd_ff[7:0];
      end
   end

endmodule

// ----- hdl/alpb_queue.sv -----
// Two-entry queue between the front and back pipelines.
module alpb_queue
   import alpb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  pix_type push_data,
   output logic full,
   output logic not_empty,
   input  logic pop,
   output pix_type pop_data
);

   pix_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ----- hdl/alpb_back.sv -----
// Back pipeline: blend the line color or accumulate opacity, hold the result beat.
module alpb_back
   import alpb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic q_not_empty,
   output logic pop,
   input  pix_type pop_data,
   input  logic [RgbWidth-1:0] line_rgb,
   input  logic alpha_only,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_write_enable,
   output logic [ColorWidth-1:0] rsp_new_red,
   output logic [ColorWidth-1:0] rsp_new_green,
   output logic [ColorWidth-1:0] rsp_new_blue
);

   localparam logic [15:0] Recip255 = 16'd32897;

   logic en;
   logic vx_ff, vy_ff;
   logic wex_ff, wey_ff;
   logic [15:0] sr_ff, sg_ff, sb_ff;
   logic [3*ColorWidth-1:0] dx_ff, oy_ff;
   logic [ColorWidth-1:0] a, ia, dr, dg, db, cr, cg, cb;
   logic [31:0] qr, qg, qb;

   assign en = !vy_ff || rsp_ready;
   assign pop = q_not_empty && en;

   // Pick destination and source per channel
   always_comb begin
      a = pop_data.alpha;
      ia = 8'd255 - a;
      if (alpha_only) begin
         dr = pop_data.dest_red;
         dg = pop_data.dest_red;
         db = pop_data.dest_red;
         cr = 8'd255;
         cg = 8'd255;
         cb = 8'd255;
      end else begin
         dr = pop_data.dest_red;
         dg = pop_data.dest_green;
         db = pop_data.dest_blue;
         cr = line_rgb[7:0];
         cg = line_rgb[15:8];
         cb = line_rgb[23:16];
      end
   end

   // Divide by 255 through the reciprocal
   assign qr = sr_ff * Recip255;
   assign qg = sg_ff * Recip255;
   assign qb = sb_ff * Recip255;

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff <= 1'b0;
         vy_ff <= 1'b0;
      end else if (en) begin
         vx_ff <= pop;
         vy_ff <= vx_ff;
      end
      if (en) begin
         sr_ff <= 16'(dr * ia) + 16'(cr * a) + 16'd127;
         sg_ff <= 16'(dg * ia) + 16'(cg * a) + 16'd127;
         sb_ff <= 16'(db * ia) + 16'(cb * a) + 16'd127;
         wex_ff <= pop_data.write_enable;
         dx_ff <= {pop_data.dest_red, pop_data.dest_green, pop_data.dest_blue};
         wey_ff <= wex_ff;
         oy_ff <= wex_ff ? {qr[30:23], qg[30:23], qb[30:23]} : dx_ff;
      end
   end

   assign rsp_valid = vy_ff;
   assign rsp_write_enable = wey_ff;
   assign rsp_new_red = oy_ff[23:16];
   assign rsp_new_green = oy_ff[15:8];
   assign rsp_new_blue = oy_ff[7:0];

endmodule

// ----- tb/antialiased_line_pixel_blend_core_tb.sv -----
// Self-checking testbench for the antialiased line pixel blend core.
`timescale 1ns / 100ps

module antialiased_line_pixel_blend_core_tb;
   import alpb_pkg::*;

   localparam int FrameW = FrameWidthDefault;
   localparam int FrameH = FrameHeightDefault;

   // Line settings as the predictor sees them
   typedef struct {
      logic signed [CoordWidth-1:0] sx, sy, ex, ey;
      logic [LineWidthWidth-1:0] lw;
      logic [RgbWidth-1:0] rgb;
      logic [ColorWidth-1:0] opacity;
      logic alpha_only;
   } line_cfg_type;

   typedef struct {
      logic we;
      logic [ColorWidth-1:0] r, g, b;
   } pixel_out_type;

   // Shader predictor and pending-pixel store
   class shade_scoreboard;
      line_cfg_type cfg;
      pixel_out_type pending[$];
      int errors;

      function new();
         errors = 0;
         cfg.sx = 0; cfg.sy = 0; cfg.ex = 0; cfg.ey = 0;
         cfg.lw = LINE_WIDTH_RESET;
         cfg.rgb = LINE_RGB_RESET;
         cfg.opacity = LINE_OPACITY_RESET;
         cfg.alpha_only = 1'b0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] v);
         case (idx)
            CSR_START_X: cfg.sx = v[CoordWidth-1:0];
            CSR_START_Y: cfg.sy = v[CoordWidth-1:0];
            CSR_END_X: cfg.ex = v[CoordWidth-1:0];
            CSR_END_Y: cfg.ey = v[CoordWidth-1:0];
            CSR_LINE_WIDTH: cfg.lw = v[LineWidthWidth-1:0];
            CSR_LINE_RGB: cfg.rgb = v;
            CSR_LINE_OPACITY: cfg.opacity = v[ColorWidth-1:0];
            CSR_ALPHA_ONLY: cfg.alpha_only = v[0];
            default: ;
         endcase
      endfunction

      function longint root_floor(longint v);
         longint r, c;
         r = 0;
         for (int k = 31; k >= 0; k--) begin
            c = r | (longint'(1) << k);
            if (c * c <= v) r = c;
         end
         return r;
      endfunction

      function longint unit_q14(longint d, longint len8);
         longint m, q;
         m = d < 0 ? -d : d;
         q = ((m << 22) + len8 / 2) / len8;
         if (q > 16384) q = 16384;
         return d < 0 ? -q : q;
      endfunction

      function longint round_q14(longint s);
         longint m;
         m = s < 0 ? -s : s;
         return (m + 8192) >>> 14;
      endfunction

      function logic [7:0] mix(longint d, longint s, longint a);
         return 8'((d * (255 - a) + s * a + 127) / 255);
      endfunction

      // Note an accepted pixel and queue its expected shade
      function void note_pixel(logic [11:0] x, logic [11:0] y, logic [7:0] dr,
                               logic [7:0] dg, logic [7:0] db);
         longint sx, sy, dx, dy, lsq, len8, ux, uy, px, py, ns, ts, n, t, hw, c, a, v;
         pixel_out_type o;
         sx = cfg.sx; sy = cfg.sy;
         dx = longint'(cfg.ex) - sx; dy = longint'(cfg.ey) - sy;
         lsq = dx * dx + dy * dy;
         a = 0;
         o.we = 0; o.r = dr; o.g = dg; o.b = db;
         if (lsq != 0 && x < FrameW && y < FrameH) begin
            len8 = root_floor(lsq << 16);
            ux = unit_q14(dx, len8); uy = unit_q14(dy, len8);
            px = (longint'(x) - sx) * 256 + 128;
            py = (longint'(y) - sy) * 256 + 128;
            ns = px * (-uy) + py * ux;
            ts = px * ux + py * uy;
            n = round_q14(ns);
            t = ts < 0 ? -round_q14(ts) : round_q14(ts);
            hw = longint'(cfg.lw) * 8;
            if (n <= hw + 256 && t >= -256 && t <= len8 + 256) begin
               c = 256;
               if (n > hw) c = 256 - (n - hw);
               if (t < 0 && 256 + t < c) c = 256 + t;
               else if (t > len8 && 256 - (t - len8) < c) c = 256 - (t - len8);
               if (c < 0) c = 0;
               a = (c * cfg.opacity + 128) >>> 8;
               o.we = a > 0;
            end
         end
         if (o.we) begin
            if (cfg.alpha_only) begin
               v = (a * 255 + longint'(dr) * (255 - a) + 127) / 255;
               o.r = 8'(v); o.g = 8'(v); o.b = 8'(v);
            end else begin
               o.r = mix(dr, cfg.rgb[7:0], a);
               o.g = mix(dg, cfg.rgb[15:8], a);
               o.b = mix(db, cfg.rgb[23:16], a);
            end
         end
         pending.push_back(o);
      endfunction

      // Compare one result beat against the oldest expectation
      function void check_pixel(logic we, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         pixel_out_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (we !== e.we) begin
            $error("write_enable expected %0d actual %0d", e.we, we); errors++;
         end
         if (r !== e.r) begin
            $error("new_red expected %0d actual %0d", e.r, r); errors++;
         end
         if (g !== e.g) begin
            $error("new_green expected %0d actual %0d", e.g, g); errors++;
         end
         if (b !== e.b) begin
            $error("new_blue expected %0d actual %0d", e.b, b); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;
   logic req_valid, req_ready;
   logic [PixelWidth-1:0] req_pixel_x, req_pixel_y;
   logic [ColorWidth-1:0] req_dest_red, req_dest_green, req_dest_blue;
   logic rsp_valid, rsp_ready, rsp_write_enable;
   logic [ColorWidth-1:0] rsp_new_red, rsp_new_green, rsp_new_blue;

   shade_scoreboard board;
   int send_idle_pct, recv_idle_pct;

   antialiased_line_pixel_blend_core dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL antialiased_line_pixel_blend_core");
      $finish;
   end

   // Random receiver stall; check each result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_pixel(rsp_write_enable, rsp_new_red, rsp_new_green, rsp_new_blue);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hold the write enable high; the next pixel or drain drops it
   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   // Drain outstanding results before touching the registers
   task automatic wait_idle();
      csr_we <= 1'b0;
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_line(int sx, int sy, int ex, int ey, int lw, int rgb, int op, int ao);
      wait_idle();
      write_csr(CSR_START_X, CsrDataWidth'(sx));
      write_csr(CSR_START_Y, CsrDataWidth'(sy));
      write_csr(CSR_END_X, CsrDataWidth'(ex));
      write_csr(CSR_END_Y, CsrDataWidth'(ey));
      write_csr(CSR_LINE_WIDTH, CsrDataWidth'(lw));
      write_csr(CSR_LINE_RGB, CsrDataWidth'(rgb));
      write_csr(CSR_LINE_OPACITY, CsrDataWidth'(op));
      write_csr(CSR_ALPHA_ONLY, CsrDataWidth'(ao));
   endtask

   // Present one pixel beat, with an optional idle gap before it
   task automatic send_pixel(int x, int y, int r, int g, int b);
      csr_we <= 1'b0;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= PixelWidth'(x); req_pixel_y <= PixelWidth'(y);
      req_dest_red <= ColorWidth'(r); req_dest_green <= ColorWidth'(g);
      req_dest_blue <= ColorWidth'(b);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(PixelWidth'(x), PixelWidth'(y), ColorWidth'(r), ColorWidth'(g),
                       ColorWidth'(b));
   endtask

   function automatic int coord_near(int c);
      int v;
      v = c + $signed($urandom_range(80)) - 40;
      if (v < 0) v = $urandom_range(3);
      if (v > 4095) v = 4095;
      return v;
   endfunction

   // Random line near the frame, mostly short, sometimes extreme
   task automatic random_line();
      int sx, sy, ex, ey, lw;
      sx = $urandom_range(2100);
      sy = $urandom_range(2100);
      ex = sx + $urandom_range(120) - 60;
      ey = sy + $urandom_range(120) - 60;
      if ($urandom_range(9) == 0) begin
         sx = $urandom_range(8191); ex = $urandom_range(8191);
         sy = $urandom_range(8191); ey = $urandom_range(8191);
      end
      lw = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(120);
      set_line(sx, sy, ex, ey, lw, $urandom_range(24'hFFFFFF), $urandom_range(255),
               $urandom_range(1));
   endtask

   task automatic random_pixels(int count);
      int cx, cy;
      cx = (board.cfg.sx + board.cfg.ex) / 2;
      cy = (board.cfg.sy + board.cfg.ey) / 2;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(4) == 0)
            send_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
         else
            send_pixel(coord_near(cx), coord_near(cy), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 0; recv_idle_pct = 0;
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_valid = 1'b0; req_pixel_x = '0; req_pixel_y = '0;
      req_dest_red = '0; req_dest_green = '0; req_dest_blue = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Degenerate line at reset values
      send_pixel(0, 0, 12, 34, 56);
      // Out-of-range register index is dropped
      wait_idle();
      write_csr(4'd8, 24'hFFFFFF);
      write_csr(4'd15, 24'h123456);

      // Horizontal line, color mode: ends, edges, off frame, extremes
      set_line(10, 10, 50, 10, 40, 24'h80FF00, 255, 0);
      send_pixel(30, 10, 0, 0, 0);
      send_pixel(30, 12, 255, 255, 255);
      send_pixel(30, 14, 1, 2, 3);
      send_pixel(9, 10, 100, 100, 100);
      send_pixel(51, 10, 100, 100, 100);
      send_pixel(2047, 10, 5, 5, 5);
      send_pixel(2048, 10, 5, 5, 5);
      send_pixel(30, 4095, 5, 5, 5);
      send_pixel(4095, 4095, 255, 0, 255);
      // Zero opacity
      set_line(10, 10, 50, 10, 40, 24'h80FF00, 0, 0);
      send_pixel(30, 10, 7, 8, 9);
      // Alpha mode, extreme coordinates and widths
      set_line(-4096, -4096, 4095, 4095, 1023, 24'h000000, 128, 1);
      send_pixel(1000, 1000, 200, 0, 0);
      send_pixel(0, 2047, 0, 255, 255);
      set_line(4095, 0, -4096, 0, 0, 24'hFFFFFF, 255, 1);
      send_pixel(5, 0, 77, 1, 1);
      send_pixel(5, 1, 77, 1, 1);

      // Random phases with shifting idle patterns
      for (int ph = 0; ph < 30; ph++) begin
         if (ph == 10) begin send_idle_pct = 57; recv_idle_pct = 24; end
         else if (ph == 20) begin send_idle_pct = 0; recv_idle_pct = 0; end
         else if (ph == 0) begin send_idle_pct = 24; recv_idle_pct = 57; end
         random_line();
         random_pixels(13);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS antialiased_line_pixel_blend_core");
      else
         $display("FAIL antialiased_line_pixel_blend_core");
      $finish;
   end
endmodule
